[rtl/core/pcmac_pkg.sv]
// Shared types and constants for the per-channel moving average change unit.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package pcmac_pkg;

    localparam int WINDOW_DEF   = 20;
    localparam int CHANNELS_DEF = 64;

    localparam int CH_W       = 6;
    localparam int STAMP_W    = 31;
    localparam int AVG_W      = 32;
    localparam int DIFF_W     = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    // result queue behind the pipeline
    localparam int OUT_DEPTH = 16;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        ACT_SAMPLE = 1'b0,
        ACT_CLEAR  = 1'b1
    } t_action;

    typedef struct packed {
        logic                    changed;
        logic signed [AVG_W-1:0] average;
    } t_result;

    // exact window sum width: one interval plus log2 of the window
    function automatic int sum_width(input int window);
        return AVG_W + $clog2(window);
    endfunction

endpackage

`default_nettype wire

[rtl/core/pcmac_state.sv]
// Channel state pipeline: stamp/slot memory, window sum memory and interval ring.
// Reads, updates and writes back per item with forwarding. Depends on pcmac_pkg.
`default_nettype none

module pcmac_state
    import pcmac_pkg::*;
#(
    parameter int   WINDOW   = WINDOW_DEF,
    parameter int   CHANNELS = CHANNELS_DEF,
    localparam int  SUM_W    = sum_width(WINDOW)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire t_action                 i_action,
    input  wire logic [CH_W-1:0]         i_channel,
    input  wire logic [STAMP_W-1:0]      i_stamp,
    output logic                         o_valid,
    output logic signed [SUM_W-1:0]      o_old_sum,
    output logic signed [SUM_W-1:0]      o_new_sum
);

    localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIDE_W     = CH_W + IDX_W;
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam int RING_DEPTH = CHANNELS * WINDOW;
    localparam int RING_AW    = $clog2(RING_DEPTH);

    typedef struct packed {
        logic               full;
        logic [SLOT_W-1:0]  slot;
        logic [STAMP_W-1:0] stamp;
    } t_meta;

    t_meta                    r_meta_mem [CHANNELS];
    logic signed [SUM_W-1:0]  r_sum_mem  [CHANNELS];
    logic signed [DIFF_W-1:0] r_ring_mem [RING_DEPTH];
    logic [CHANNELS-1:0]      r_chan_vld;

    // input decode
    logic [WIDE_W-1:0] in_wide;
    logic              in_range;
    logic [IDX_W-1:0]  in_idx;

    assign in_wide  = WIDE_W'(i_channel);
    assign in_range = in_wide < WIDE_W'(CHANNELS);
    assign in_idx   = in_range ? in_wide[IDX_W-1:0] : '0;

    // stage 1 registers
    logic               r_s1_valid;
    logic               r_s1_inrange;
    t_action            r_s1_action;
    logic [IDX_W-1:0]   r_s1_idx;
    logic [STAMP_W-1:0] r_s1_stamp;
    t_meta              r_meta_rd;

    // stage 2 registers
    logic                     r_s2_valid;
    logic                     r_s2_sample;
    logic [IDX_W-1:0]         r_s2_idx;
    logic signed [DIFF_W-1:0] r_s2_diff;
    logic [RING_AW-1:0]       r_s2_ring_addr;
    logic                     r_s2_full;
    logic                     r_s2_had;
    t_meta                    r_s2_meta;
    logic signed [DIFF_W-1:0] r_ring_rd;
    logic signed [SUM_W-1:0]  r_sum_rd;

    // stage 3 registers
    logic                    r_s3_valid;
    logic                    r_s3_sample;
    logic [IDX_W-1:0]        r_s3_idx;
    logic signed [SUM_W-1:0] r_s3_old_sum;
    logic signed [SUM_W-1:0] r_s3_new_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s1_inrange <= in_range;
            r_s1_action  <= i_action;
            r_s1_idx     <= in_idx;
            r_s1_stamp   <= i_stamp;
            r_meta_rd    <= r_meta_mem[in_idx];
        end
    end

    // stage 1: resolve channel state, advance slot, take interval
    logic                     s1_sample;
    logic                     s1_clear;
    t_meta                    s1_meta;
    t_meta                    s1_meta_new;
    logic                     s1_last_slot;
    logic signed [DIFF_W-1:0] s1_diff;
    logic [RING_AW-1:0]       s1_ring_addr;

    assign s1_sample = r_s1_valid && r_s1_inrange && (r_s1_action == ACT_SAMPLE);
    assign s1_clear  = r_s1_valid && r_s1_inrange && (r_s1_action == ACT_CLEAR);

    always_comb begin
        // the item one ahead wrote its state at the edge our read sampled
        if (r_s2_sample && (r_s2_idx == r_s1_idx)) begin
            s1_meta = r_s2_meta;
        end else if (!r_chan_vld[r_s1_idx]) begin
            s1_meta = '0;
        end else begin
            s1_meta = r_meta_rd;
        end
        s1_last_slot      = s1_meta.slot == SLOT_W'(WINDOW - 1);
        s1_meta_new.full  = s1_meta.full | s1_last_slot;
        s1_meta_new.slot  = s1_last_slot ? '0 : s1_meta.slot + 1'b1;
        s1_meta_new.stamp = r_s1_stamp;
        s1_diff           = DIFF_W'({1'b0, r_s1_stamp}) - DIFF_W'({1'b0, s1_meta.stamp});
        s1_ring_addr      = RING_AW'(r_s1_idx) * RING_AW'(WINDOW) + RING_AW'(s1_meta.slot);
    end

    always_ff @(posedge i_clk) begin
        if (s1_sample) begin
            r_meta_mem[r_s1_idx] <= s1_meta_new;
        end
        if (r_s1_valid) begin
            r_ring_rd <= r_ring_mem[s1_ring_addr];
            r_sum_rd  <= r_sum_mem[r_s1_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_vld  <= '0;
            r_s2_valid  <= 1'b0;
            r_s2_sample <= 1'b0;
        end else begin
            if (s1_sample) begin
                r_chan_vld[r_s1_idx] <= 1'b1;
            end else if (s1_clear) begin
                r_chan_vld[r_s1_idx] <= 1'b0;
            end
            r_s2_valid  <= r_s1_valid;
            r_s2_sample <= s1_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_idx       <= r_s1_idx;
            r_s2_diff      <= s1_diff;
            r_s2_ring_addr <= s1_ring_addr;
            r_s2_full      <= s1_meta.full;
            r_s2_had       <= r_chan_vld[r_s1_idx];
            r_s2_meta      <= s1_meta_new;
        end
    end

    // stage 2: drop the oldest interval, add the new one
    logic signed [DIFF_W-1:0] s2_ring_old;
    logic signed [SUM_W-1:0]  s2_sum_old;
    logic signed [SUM_W-1:0]  s2_sum_new;

    always_comb begin
        s2_ring_old = r_s2_full ? r_ring_rd : '0;
        if (!r_s2_had) begin
            s2_sum_old = '0;
        end else if (r_s3_sample && (r_s3_idx == r_s2_idx)) begin
            s2_sum_old = r_s3_new_sum;
        end else begin
            s2_sum_old = r_sum_rd;
        end
        s2_sum_new = s2_sum_old - SUM_W'(s2_ring_old) + SUM_W'(r_s2_diff);
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_sample) begin
            r_sum_mem[r_s2_idx]        <= s2_sum_new;
            r_ring_mem[r_s2_ring_addr] <= r_s2_diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_s3_sample <= 1'b0;
        end else begin
            r_s3_valid  <= r_s2_valid;
            r_s3_sample <= r_s2_sample;
        end
    end

    // clear and out-of-range items carry zero sums, which round to zero
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_s3_idx     <= r_s2_idx;
            r_s3_old_sum <= r_s2_sample ? s2_sum_old : '0;
            r_s3_new_sum <= r_s2_sample ? s2_sum_new : '0;
        end
    end

    assign o_valid   = r_s3_valid;
    assign o_old_sum = r_s3_old_sum;
    assign o_new_sum = r_s3_new_sum;

endmodule

`default_nettype wire

[rtl/core/pcmac_div.sv]
// Pipelined rounded division of a signed window sum by the window length.
// Reciprocal multiply in two partial products, then one correction step. Depends on pcmac_pkg.
`default_nettype none

module pcmac_div
    import pcmac_pkg::*;
#(
    parameter int  WINDOW = WINDOW_DEF,
    localparam int SUM_W  = sum_width(WINDOW)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic signed [SUM_W-1:0] i_sum,
    output logic                         o_valid,
    output logic signed [AVG_W-1:0]      o_avg
);

    localparam int DIVISOR = 2 * WINDOW;
    localparam int X_W     = SUM_W;
    localparam int K       = X_W;
    localparam int XL      = X_W / 2;
    localparam int XH      = X_W - XL;
    localparam int P_W     = X_W + K;
    localparam int D_W     = $clog2(DIVISOR + 1);
    localparam int QD_W    = AVG_W + D_W;
    localparam logic [K-1:0] RECIP = K'((64'd1 << K) / DIVISOR);

    logic [4:0] r_vld;

    logic [X_W-1:0]    r_a_x;
    logic              r_a_neg;
    logic [XL+K-1:0]   r_b_plo;
    logic [XH+K-1:0]   r_b_phi;
    logic [X_W-1:0]    r_b_x;
    logic              r_b_neg;
    logic [AVG_W-1:0]  r_c_q;
    logic [X_W-1:0]    r_c_x;
    logic              r_c_neg;
    logic [QD_W-1:0]   r_d_qd;
    logic [AVG_W-1:0]  r_d_q;
    logic [X_W-1:0]    r_d_x;
    logic              r_d_neg;
    logic signed [AVG_W-1:0] r_e_avg;

    // 2*|sum| + WINDOW in one add: modular arithmetic handles the negative side
    logic [SUM_W:0] two_s;
    logic [SUM_W:0] x_full;
    logic [P_W-1:0] prod;
    logic [X_W-1:0] rem;
    logic [AVG_W-1:0] q_fix;

    always_comb begin
        two_s  = {i_sum, 1'b0};
        x_full = i_sum[SUM_W-1] ? (SUM_W+1)'(WINDOW) - two_s
                                : two_s + (SUM_W+1)'(WINDOW);
        prod   = {r_b_phi, {XL{1'b0}}} + P_W'(r_b_plo);
        rem    = r_d_x - X_W'(r_d_qd);
        q_fix  = r_d_q + AVG_W'(rem >= X_W'(DIVISOR));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_x   <= x_full[X_W-1:0];
        r_a_neg <= i_sum[SUM_W-1];

        r_b_plo <= (XL+K)'(r_a_x[XL-1:0]) * (XL+K)'(RECIP);
        r_b_phi <= (XH+K)'(r_a_x[X_W-1:XL]) * (XH+K)'(RECIP);
        r_b_x   <= r_a_x;
        r_b_neg <= r_a_neg;

        // estimate is the quotient or one below it
        r_c_q   <= prod[K +: AVG_W];
        r_c_x   <= r_b_x;
        r_c_neg <= r_b_neg;

        r_d_qd  <= QD_W'(r_c_q) * QD_W'(DIVISOR);
        r_d_q   <= r_c_q;
        r_d_x   <= r_c_x;
        r_d_neg <= r_c_neg;

        r_e_avg <= r_d_neg ? -q_fix : q_fix;
    end

    assign o_valid = r_vld[4];
    assign o_avg   = r_e_avg;

endmodule

`default_nettype wire

[rtl/core/pcmac_outq.sv]
// Result queue between the fixed-latency pipeline and the output stream.
// Register-based FIFO of OUT_DEPTH entries. Depends on pcmac_pkg.
`default_nettype none

module pcmac_outq
    import pcmac_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_result      o_data
);

    t_result              r_mem [OUT_DEPTH];
    logic [OUT_AW-1:0]    r_wr_ptr;
    logic [OUT_AW-1:0]    r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + OUT_CNT_W'(i_push) - OUT_CNT_W'(pop_ok);
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

[rtl/core/per_channel_moving_average_change_unit.sv]
// Per-channel moving average of timestamp intervals with change detection.
// Top level: pcmac_state, two pcmac_div units and pcmac_outq. Depends on pcmac_pkg.
//
// Usage:
//   Input stream s_axis: tuser = action (0 sample, 1 clear channel),
//   tdata = channel in [5:0], stamp in [36:6], zero padded to 40 bits.
//   Output stream m_axis: tuser = changed flag, tdata = rounded average.
//   Every input item yields exactly one result item, in order.
//   Throughput: one item per cycle while s_axis_tready is high; each item
//   makes one read and one write on the state memories and the interval
//   ring, and back-to-back items on the same channel are forwarded.
//   Reset clears the per-channel valid bits, the pipeline and the result
//   queue; memory contents are masked by the valid bits, the ring fill flag
//   and the slot order, so no clearing sweep is run.
//   When m_axis_tready is low, results collect in a 16-entry queue; the
//   block keeps accepting until queued plus in-flight items reach 16, then
//   drops s_axis_tready until results are taken.
`default_nettype none

module per_channel_moving_average_change_unit
    import pcmac_pkg::*;
#(
    parameter int WINDOW   = WINDOW_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [5:0] channel, [36:6] stamp
    input  wire logic [0:0]            s_axis_tuser,   // [0] action
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [31:0] average
    output logic [0:0]                 m_axis_tuser    // [0] changed
);

    localparam int SUM_W = sum_width(WINDOW);

    logic                    in_accept;
    logic                    out_pop;
    logic [OUT_CNT_W-1:0]    r_occ;
    logic [OUT_CNT_W-1:0]    n_occ;

    logic                    st_valid;
    logic signed [SUM_W-1:0] st_old_sum;
    logic signed [SUM_W-1:0] st_new_sum;

    logic                    dv_old;
    logic                    dv_new;
    logic signed [AVG_W-1:0] avg_old;
    logic signed [AVG_W-1:0] avg_new;

    t_result                 res_push;
    t_result                 res_head;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = r_occ < OUT_CNT_W'(OUT_DEPTH);

    // items accepted and not yet delivered, in flight or queued
    assign n_occ = r_occ + OUT_CNT_W'(in_accept) - OUT_CNT_W'(out_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    pcmac_state #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_accept),
        .i_action  (t_action'(s_axis_tuser[0])),
        .i_channel (s_axis_tdata[CH_W-1:0]),
        .i_stamp   (s_axis_tdata[CH_W +: STAMP_W]),
        .o_valid   (st_valid),
        .o_old_sum (st_old_sum),
        .o_new_sum (st_new_sum)
    );

    // the stored average always equals the rounded old sum
    pcmac_div #(
        .WINDOW (WINDOW)
    ) u_div_old (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid),
        .i_sum   (st_old_sum),
        .o_valid (dv_old),
        .o_avg   (avg_old)
    );

    pcmac_div #(
        .WINDOW (WINDOW)
    ) u_div_new (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid),
        .i_sum   (st_new_sum),
        .o_valid (dv_new),
        .o_avg   (avg_new)
    );

    assign res_push.changed = avg_new != avg_old;
    assign res_push.average = avg_new;

    pcmac_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (dv_old && dv_new),
        .i_data  (res_push),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (res_head)
    );

    assign m_axis_tdata = res_head.average;
    assign m_axis_tuser = res_head.changed;

endmodule

`default_nettype wire

[rtl/core/pcmac_chk.sv]
// Port-level checks for the moving average change unit, bound to the top level.
// Depends on pcmac_pkg and per_channel_moving_average_change_unit.
`default_nettype none

module pcmac_chk
    import pcmac_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]            m_axis_tuser
);

    logic [OUT_CNT_W:0] r_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + (OUT_CNT_W+1)'(s_axis_tvalid && s_axis_tready)
                                   - (OUT_CNT_W+1)'(m_axis_tvalid && m_axis_tready);
        end
    end

    // no result without an accepted item still owed one
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pending != '0))
        else $error("result offered with no item outstanding");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind per_channel_moving_average_change_unit pcmac_chk u_pcmac_chk (.*);

`default_nettype wire

[dv/tb_per_channel_moving_average_change_unit.sv]
// Self-checking bench for the per-channel moving average change unit: drives sample
// and clear items with random gaps and stalls and checks every result in order.
// Depends on pcmac_pkg and per_channel_moving_average_change_unit.
`timescale 1ns / 100ps

module tb_per_channel_moving_average_change_unit;
    import pcmac_pkg::*;

    localparam int WIN = WINDOW_DEF;
    localparam int CHS = CHANNELS_DEF;

    // Per-channel interval averager; keeps its own copy of the channel state and
    // the queue of results still owed by the block.
    class average_board;
        bit signed [DIFF_W-1:0] intervals [CHS][WIN];
        bit [4:0]               slot      [CHS];
        bit [STAMP_W-1:0]       prev_stamp[CHS];
        bit signed [36:0]       run_sum   [CHS];
        bit signed [AVG_W-1:0]  held_avg  [CHS];
        t_result                owed[$];
        int mismatches;
        int checked;
        int changes;
        int negatives;
        int clears;
        int accepted;

        function void note_input(t_action act, bit [CH_W-1:0] ch, bit [STAMP_W-1:0] st);
            t_result r;
            bit signed [DIFF_W-1:0] gap_ms;
            longint mag;
            longint q;
            r.changed = 1'b0;
            r.average = '0;
            accepted++;
            if (act == ACT_CLEAR) begin
                clears++;
                for (int k = 0; k < WIN; k++) intervals[ch][k] = '0;
                slot[ch]       = '0;
                prev_stamp[ch] = '0;
                run_sum[ch]    = '0;
                held_avg[ch]   = '0;
            end else begin
                gap_ms = $signed({1'b0, st}) - $signed({1'b0, prev_stamp[ch]});
                run_sum[ch] = run_sum[ch] - intervals[ch][slot[ch]] + gap_ms;
                intervals[ch][slot[ch]] = gap_ms;
                prev_stamp[ch] = st;
                slot[ch] = (slot[ch] == WIN - 1) ? 5'd0 : slot[ch] + 5'd1;
                // round half away from zero on the magnitude
                mag = (run_sum[ch] < 0) ? -longint'(run_sum[ch]) : longint'(run_sum[ch]);
                q = (2 * mag + WIN) / (2 * WIN);
                r.average = (run_sum[ch] < 0) ? -q : q;
                if (r.average != held_avg[ch]) begin
                    held_avg[ch] = r.average;
                    r.changed = 1'b1;
                end
                r.average = held_avg[ch];
            end
            owed.push_back(r);
        endfunction

        function void check_result(logic chg, logic [AVG_W-1:0] avg);
            t_result exp_r;
            if (owed.size() == 0) begin
                $display("%0t: result with nothing pending: changed %b average %0d",
                         $time, chg, $signed(avg));
                mismatches++;
                return;
            end
            exp_r = owed.pop_front();
            checked++;
            if (chg !== exp_r.changed) begin
                $display("%0t: changed expected %b actual %b", $time, exp_r.changed, chg);
                mismatches++;
            end
            if (avg !== exp_r.average) begin
                $display("%0t: average expected %0d actual %0d",
                         $time, exp_r.average, $signed(avg));
                mismatches++;
            end
            if (exp_r.changed) changes++;
            if (exp_r.average < 0) negatives++;
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // [5:0] channel, [36:6] stamp
    logic [0:0]             s_axis_tuser = '0;   // [0] action
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;        // [31:0] average
    logic [0:0]             m_axis_tuser;        // [0] changed

    average_board board = new();

    int               sent_n;
    int               taken_n;
    bit [STAMP_W-1:0] cursor[CHS];
    int               pace[CHS];
    int               pick;
    bit [CH_W-1:0]    ch;
    bit [STAMP_W-1:0] st;

    per_channel_moving_average_change_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(t_action act, bit [CH_W-1:0] c, bit [STAMP_W-1:0] s);
        int gap;
        gap = ((sent_n / 100) % 4 == 3) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, s, c};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_input(act, c, s);
        sent_n++;
        @(negedge i_clk);
    endtask

    // Result side: stall at random, check each accepted item.
    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            gap = ((taken_n / 70) % 5 == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check_result(m_axis_tuser[0], m_axis_tdata);
            taken_n++;
            @(negedge i_clk);
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // stamp extremes, clear, first sample after a clear
        send_item(ACT_SAMPLE, 6'd63, 31'h7FFF_FFFF);
        send_item(ACT_SAMPLE, 6'd63, 31'd0);
        send_item(ACT_CLEAR,  6'd63, 31'h7FFF_FFFF);
        send_item(ACT_SAMPLE, 6'd63, 31'd10);      // sum 10 rounds up to 1
        // fill one ring, then an earlier stamp pushes the sum to -10 (rounds to -1)
        for (int k = 0; k < WIN; k++) send_item(ACT_SAMPLE, 6'd1, 31'd1000);
        send_item(ACT_SAMPLE, 6'd1, 31'd990);
        cursor[1] = 31'd990;

        for (int k = 0; k < CHS; k++) pace[k] = $urandom_range(0, 3000);

        for (int n = 0; n < 1800; n++) begin
            pick = $urandom_range(0, 99);
            // most traffic on a few channels so rings wrap many times
            ch = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 7))
                                             : 6'($urandom_range(0, 63));
            if (pick < 4) begin
                send_item(ACT_CLEAR, ch, 31'($urandom));
                cursor[ch] = '0;
            end else begin
                if (pick < 80)
                    st = cursor[ch] + 31'(pace[ch]) + 31'($urandom_range(0, 3));
                else if (pick < 90)
                    st = cursor[ch] - 31'($urandom_range(0, 5000));
                else
                    st = 31'($urandom);
                if (pick == 99) pace[ch] = $urandom_range(0, 100000);
                send_item(ACT_SAMPLE, ch, st);
                cursor[ch] = st;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d items (%0d clears) with %0d results checked,",
                 board.accepted, board.clears, board.checked);
        $display("%0d average changes and %0d negative averages seen.",
                 board.changes, board.negatives);
        if (board.mismatches == 0 && board.owed.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
